/* hw/rtl/mcc2d_pkg.sv */
// Shared types and constants for the multichannel convolution forward unit.
// No dependencies.
`default_nettype none
package mcc2d_pkg;
    localparam int MAX_IN_CH  = 8;
    localparam int MAX_OUT_CH = 16;
    localparam int MAX_K      = 5;
    localparam int MAX_DIM    = 32;
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 40;
    localparam int W_DEPTH    = MAX_OUT_CH * MAX_IN_CH * MAX_K * MAX_K;
    localparam int B_DEPTH    = MAX_OUT_CH * MAX_DIM * MAX_DIM;
    localparam int L_DEPTH    = MAX_K * MAX_DIM * MAX_IN_CH;
    localparam int WA_W       = 12;
    localparam int BA_W       = 14;
    localparam int LA_W       = $clog2(L_DEPTH);

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_PIXEL  = 2'd2;

    localparam logic [2:0] REG_IN_CH  = 3'd0;
    localparam logic [2:0] REG_OUT_CH = 3'd1;
    localparam logic [2:0] REG_K_ROWS = 3'd2;
    localparam logic [2:0] REG_K_COLS = 3'd3;
    localparam logic [2:0] REG_I_ROWS = 3'd4;
    localparam logic [2:0] REG_I_COLS = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [WA_W-1:0]    weight_addr;
        logic [BA_W-1:0]    bias_addr;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         filter_index;
        logic [4:0]         out_row;
        logic [4:0]         out_col;
        logic signed [15:0] result_value;
        logic               clipped;
        logic               run_last;
        logic               frame_done;
    } t_out_item;

    // Effective (clamped) geometry seen by both parts.
    typedef struct packed {
        logic [3:0] ic;
        logic [4:0] oc;
        logic [2:0] kr;
        logic [2:0] kc;
        logic [5:0] ir;
        logic [5:0] icol;
    } t_geom;

    // One window job handed from the front part to the back part.
    typedef struct packed {
        logic [4:0] orow;
        logic [4:0] ocol;
        logic       last_win;
    } t_job;
endpackage
`default_nettype wire

/* hw/rtl/multichannel_conv2d_forward_unit.sv */
// Top level of the multichannel convolution forward unit: register port,
// front part, job queue and back part. Depends on mcc2d_pkg and submodules.
//
//  channel | direction | handshake      | payload
//  in      | input     | valid/ready    | t_in_item
//  out     | output    | valid/ready    | t_out_item
//  config  | input     | APB write/read | 6 registers at 4*i
//
// Accepted load requests write their store directly. A pixel that completes a window
// queues a job; for each filter the back part then accumulates ic*kr*kc products and
// passes through drain, bias, saturate and output, all on the single shared
// multiply-accumulate unit. Reset needs no clearing pass. The input stalls when the
// job queue is full, and loads and the first pixel of a row wait while any window is
// queued or running.
`default_nettype none
module multichannel_conv2d_forward_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  mcc2d_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output mcc2d_pkg::t_out_item o_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [4:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mcc2d_pkg::*;

    logic [3:0] r_ic;  logic [4:0] r_oc;
    logic [2:0] r_kr;  logic [2:0] r_kc;
    logic [5:0] r_ir;  logic [5:0] r_icol;
    logic       wr;
    logic       restart;
    t_geom      geom;
    logic [2:0] ridx;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign ridx    = paddr[4:2];
    assign restart = wr && (ridx <= REG_I_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= 4'd1; r_oc <= 5'd1; r_kr <= 3'd3; r_kc <= 3'd3;
            r_ir <= 6'd32; r_icol <= 6'd32;
        end else if (wr) begin
            case (ridx)
                REG_IN_CH:  r_ic   <= pwdata[3:0];
                REG_OUT_CH: r_oc   <= pwdata[4:0];
                REG_K_ROWS: r_kr   <= pwdata[2:0];
                REG_K_COLS: r_kc   <= pwdata[2:0];
                REG_I_ROWS: r_ir   <= pwdata[5:0];
                REG_I_COLS: r_icol <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_IN_CH:  prdata = {28'd0, r_ic};
            REG_OUT_CH: prdata = {27'd0, r_oc};
            REG_K_ROWS: prdata = {29'd0, r_kr};
            REG_K_COLS: prdata = {29'd0, r_kc};
            REG_I_ROWS: prdata = {26'd0, r_ir};
            REG_I_COLS: prdata = {26'd0, r_icol};
            default:    prdata = 32'd0;
        endcase
        geom.ic   = (r_ic == 0) ? 4'd1 : (r_ic > 4'd8) ? 4'd8 : r_ic;
        geom.oc   = (r_oc == 0) ? 5'd1 : (r_oc > 5'd16) ? 5'd16 : r_oc;
        geom.kr   = (r_kr == 0) ? 3'd1 : (r_kr > 3'd5) ? 3'd5 : r_kr;
        geom.kc   = (r_kc == 0) ? 3'd1 : (r_kc > 3'd5) ? 3'd5 : r_kc;
        geom.ir   = (r_ir == 0) ? 6'd1 : (r_ir > 6'd32) ? 6'd32 : r_ir;
        geom.icol = (r_icol == 0) ? 6'd1 : (r_icol > 6'd32) ? 6'd32 : r_icol;
    end

    logic job_full, job_push, job_pop, job_empty;
    logic back_busy, busy;
    t_job job_in, job_out;
    logic wwr, bwr, lwr;
    logic [WA_W-1:0] waddr;
    logic [BA_W-1:0] baddr;
    logic [LA_W-1:0] laddr;
    logic signed [15:0] wdata;

    assign busy = back_busy || !job_empty;

    mcc2d_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item, .i_geom(geom),
        .i_restart(restart), .i_busy(busy), .i_job_full(job_full), .o_job_push(job_push),
        .o_job(job_in),
        .o_wwr(wwr), .o_waddr(waddr), .o_bwr(bwr), .o_baddr(baddr),
        .o_lwr(lwr), .o_laddr(laddr), .o_data(wdata)
    );

    mcc2d_job_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(job_push), .i_job(job_in), .o_full(job_full),
        .i_pop(job_pop), .o_empty(job_empty), .o_job(job_out)
    );

    mcc2d_back u_back (
        .i_clk, .i_rst_n, .i_geom(geom), .i_wwr(wwr), .i_waddr(waddr),
        .i_bwr(bwr), .i_baddr(baddr), .i_lwr(lwr), .i_laddr(laddr), .i_data(wdata),
        .i_job_empty(job_empty), .i_job(job_out), .o_job_pop(job_pop),
        .o_busy(back_busy), .o_valid, .i_ready, .o_item
    );
endmodule
`default_nettype wire

/* hw/rtl/mcc2d_front.sv */
// Front part: accepts requests, writes stores, tracks the pixel position and
// queues window jobs. Depends on mcc2d_pkg.
`default_nettype none
module mcc2d_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  mcc2d_pkg::t_in_item  i_item,
    input  mcc2d_pkg::t_geom     i_geom,
    input  wire                  i_restart,
    input  wire                  i_busy,
    input  wire                  i_job_full,
    output logic                 o_job_push,
    output mcc2d_pkg::t_job      o_job,
    output logic                 o_wwr,
    output logic [mcc2d_pkg::WA_W-1:0] o_waddr,
    output logic                 o_bwr,
    output logic [mcc2d_pkg::BA_W-1:0] o_baddr,
    output logic                 o_lwr,
    output logic [mcc2d_pkg::LA_W-1:0] o_laddr,
    output logic signed [15:0]   o_data
);
    import mcc2d_pkg::*;

    logic [4:0] r_row, n_row;
    logic [4:0] r_col, n_col;
    logic [2:0] r_chan, n_chan;
    logic [2:0] r_slot, n_slot;   // row modulo MAX_K, kept incrementally
    logic       acc_ok;
    logic       wrap, last_ch, win;
    logic [4:0] row_e, col_e, orow, ocol;
    logic [2:0] chan_e, slot_e;
    logic [5:0] row1, col1;

    // Loads and the first pixel of a row would overwrite store entries that queued
    // or running windows still read, so they wait until the back part has finished.
    assign o_ready = !i_job_full
                     && !(i_busy && (i_item.cmd != CMD_PIXEL
                                     || (col_e == 5'd0 && chan_e == 3'd0)));
    assign acc_ok  = i_valid && o_ready;

    always_comb begin
        wrap    = ({1'b0, r_row} >= i_geom.ir) || ({1'b0, r_col} >= i_geom.icol)
                  || ({1'b0, r_chan} >= i_geom.ic);
        row_e   = wrap ? 5'd0 : r_row;
        col_e   = wrap ? 5'd0 : r_col;
        chan_e  = wrap ? 3'd0 : r_chan;
        slot_e  = wrap ? 3'd0 : r_slot;
        last_ch = ({1'b0, chan_e} + 4'd1) >= i_geom.ic;
        row1    = {1'b0, row_e} + 6'd1;
        col1    = {1'b0, col_e} + 6'd1;
        win     = ({3'd0, i_geom.kr} <= i_geom.ir) && ({3'd0, i_geom.kc} <= i_geom.icol)
                  && (row1 >= {3'd0, i_geom.kr}) && (col1 >= {3'd0, i_geom.kc});
        orow    = 5'(row1 - {3'd0, i_geom.kr});
        ocol    = 5'(col1 - {3'd0, i_geom.kc});
        n_row = r_row; n_col = r_col; n_chan = r_chan; n_slot = r_slot;
        if (acc_ok && i_item.cmd == CMD_PIXEL) begin
            n_row = row_e; n_col = col_e; n_slot = slot_e;
            if (!last_ch) begin
                n_chan = chan_e + 3'd1;
            end else begin
                n_chan = 3'd0;
                if (col1 >= i_geom.icol) begin
                    n_col = 5'd0;
                    if (row1 >= i_geom.ir) begin
                        n_row = 5'd0; n_slot = 3'd0;
                    end else begin
                        n_row  = 5'(row1);
                        n_slot = (slot_e == 3'(MAX_K - 1)) ? 3'd0 : slot_e + 3'd1;
                    end
                end else begin
                    n_col = 5'(col1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0; r_col <= '0; r_chan <= '0; r_slot <= '0;
        end else begin
            r_row <= n_row; r_col <= n_col; r_chan <= n_chan; r_slot <= n_slot;
        end
    end

    assign o_data     = i_item.sample;
    assign o_waddr    = i_item.weight_addr;
    assign o_baddr    = i_item.bias_addr;
    assign o_wwr      = acc_ok && i_item.cmd == CMD_WEIGHT
                        && {1'b0, i_item.weight_addr} < 13'(W_DEPTH);
    assign o_bwr      = acc_ok && i_item.cmd == CMD_BIAS;
    assign o_lwr      = acc_ok && i_item.cmd == CMD_PIXEL;
    assign o_laddr    = LA_W'((32'(slot_e) * MAX_DIM + 32'(col_e)) * MAX_IN_CH + 32'(chan_e));
    assign o_job_push = o_lwr && last_ch && win;
    assign o_job.orow = orow;
    assign o_job.ocol = ocol;
    assign o_job.last_win = (6'(orow) == 6'(i_geom.ir - {3'd0, i_geom.kr}))
                         && (6'(ocol) == 6'(i_geom.icol - {3'd0, i_geom.kc}));
endmodule
`default_nettype wire

/* hw/rtl/mcc2d_job_fifo.sv */
// Short queue of window jobs between the front and back parts.
// Depends on mcc2d_pkg.
`default_nettype none
module mcc2d_job_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mcc2d_pkg::t_job   i_job,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output mcc2d_pkg::t_job   o_job
);
    import mcc2d_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mcc2d_back.sv */
// Back part: owns the stores and the shared multiply-accumulate sequencer
// that works out one result per filter for each queued window.
// Depends on mcc2d_pkg.
`default_nettype none
module mcc2d_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mcc2d_pkg::t_geom     i_geom,
    input  wire                  i_wwr,
    input  wire [mcc2d_pkg::WA_W-1:0] i_waddr,
    input  wire                  i_bwr,
    input  wire [mcc2d_pkg::BA_W-1:0] i_baddr,
    input  wire                  i_lwr,
    input  wire [mcc2d_pkg::LA_W-1:0] i_laddr,
    input  wire signed [15:0]    i_data,
    input  wire                  i_job_empty,
    input  mcc2d_pkg::t_job      i_job,
    output logic                 o_job_pop,
    output logic                 o_busy,
    output logic                 o_valid,
    input  wire                  i_ready,
    output mcc2d_pkg::t_out_item o_item
);
    import mcc2d_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_BIAS, S_SAT, S_OUT} t_state;

    logic signed [15:0] r_wmem [W_DEPTH];
    logic signed [15:0] r_bmem [B_DEPTH];
    logic signed [15:0] r_lmem [L_DEPTH];

    t_state     r_state;
    t_job       r_job;
    logic [3:0] r_f;
    logic [2:0] r_c, r_r, r_k;
    logic [2:0] r_slot;       // (orow + r) modulo MAX_K
    logic       r_pv, r_mv;   // read data and product valid
    logic signed [15:0] r_px, r_w, r_bias;
    logic signed [31:0] r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic signed [28:0] r_sum;
    logic signed [29:0] r_val;
    logic               r_lt_d1, r_lt_d2;
    logic [LA_W-1:0]    laddr;
    logic [WA_W-1:0]    waddr;
    logic [BA_W-1:0]    baddr;
    logic               last_tap;
    logic [2:0]         slot0;

    // Line store slot of an output row, by compare and subtract.
    function automatic logic [2:0] row_slot(input logic [4:0] row);
        logic [4:0] v;
        v = row;
        if (v >= 5'(4 * MAX_K)) v = v - 5'(4 * MAX_K);
        if (v >= 5'(2 * MAX_K)) v = v - 5'(2 * MAX_K);
        if (v >= 5'(MAX_K)) v = v - 5'(MAX_K);
        return v[2:0];
    endfunction

    assign laddr = LA_W'((32'(r_slot) * MAX_DIM + 32'(r_job.ocol) + 32'(r_k)) * MAX_IN_CH
                         + 32'(r_c));
    assign waddr = WA_W'(((32'(r_f) * MAX_IN_CH + 32'(r_c)) * MAX_K + 32'(r_r)) * MAX_K
                         + 32'(r_k));
    assign baddr = BA_W'((32'(r_f) * MAX_DIM + 32'(r_job.orow)) * MAX_DIM + 32'(r_job.ocol));
    assign last_tap = (3'(r_k + 3'd1) == i_geom.kc) && (3'(r_r + 3'd1) == i_geom.kr)
                      && (4'({1'b0, r_c} + 4'd1) == i_geom.ic);
    assign slot0 = row_slot(i_job.orow);
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    assign o_busy    = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (i_wwr) r_wmem[i_waddr] <= i_data;
        if (i_bwr) r_bmem[i_baddr] <= i_data;
        if (i_lwr) r_lmem[i_laddr] <= i_data;
        r_px   <= r_lmem[laddr];
        r_w    <= r_wmem[waddr];
        r_bias <= r_bmem[baddr];
        r_prod <= r_px * r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_valid <= 1'b0; r_pv <= 1'b0; r_mv <= 1'b0;
            r_f <= '0; r_c <= '0; r_r <= '0; r_k <= '0; r_slot <= '0;
            r_acc <= '0; r_lt_d1 <= 1'b0; r_lt_d2 <= 1'b0;
        end else begin
            r_mv    <= r_pv;
            r_lt_d2 <= r_lt_d1;
            if (r_mv) r_acc <= r_acc + ACC_W'(signed'(r_prod));
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job <= i_job; r_f <= '0; r_c <= '0; r_r <= '0; r_k <= '0;
                        r_slot <= slot0; r_acc <= '0; r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_pv    <= 1'b1;
                    r_lt_d1 <= last_tap;
                    if (last_tap) begin
                        r_state <= S_DRAIN;
                    end else if (3'(r_k + 3'd1) != i_geom.kc) begin
                        r_k <= r_k + 3'd1;
                    end else begin
                        r_k <= '0;
                        if (3'(r_r + 3'd1) != i_geom.kr) begin
                            r_r <= r_r + 3'd1;
                            r_slot <= (r_slot == 3'(MAX_K - 1)) ? 3'd0 : r_slot + 3'd1;
                        end else begin
                            r_r <= '0; r_c <= r_c + 3'd1;
                            r_slot <= row_slot(r_job.orow);
                        end
                    end
                end
                S_DRAIN: begin
                    // Wait until the last product has entered the accumulator.
                    r_pv <= 1'b0; r_lt_d1 <= 1'b0;
                    if (r_lt_d2 && !r_mv) r_state <= S_BIAS;
                    if (!r_pv && !r_mv) r_state <= S_BIAS;
                end
                S_BIAS: begin
                    r_sum   <= 29'(signed'(r_acc[ACC_W-1:12]));
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_val   <= 30'(r_sum) + 30'(r_bias);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_item.filter_index <= r_f;
                        o_item.out_row <= r_job.orow;
                        o_item.out_col <= r_job.ocol;
                        o_item.clipped <= (r_val > 30'sd32767) || (r_val < -30'sd32768);
                        o_item.result_value <= (r_val > 30'sd32767) ? 16'sh7fff :
                            (r_val < -30'sd32768) ? 16'sh8000 : r_val[15:0];
                        o_item.run_last <= 5'({1'b0, r_f} + 5'd1) == i_geom.oc;
                        o_item.frame_done <= (5'({1'b0, r_f} + 5'd1) == i_geom.oc)
                                             && r_job.last_win;
                        if (5'({1'b0, r_f} + 5'd1) == i_geom.oc) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_f <= r_f + 4'd1; r_c <= '0; r_r <= '0; r_k <= '0;
                            r_slot <= row_slot(r_job.orow);
                            r_acc <= '0; r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mcc2d_checker.sv */
// Port-level checks for the convolution unit, bound to the top level.
// Depends on mcc2d_pkg.
`default_nettype none
module mcc2d_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_valid,
    input wire                  i_ready,
    input mcc2d_pkg::t_out_item o_item,
    input wire                  pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("output dropped");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.frame_done |-> o_item.run_last) else $error("frame_done alone");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind multichannel_conv2d_forward_unit mcc2d_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_item, .pready
);
`default_nettype wire

/* verif/multichannel_conv2d_forward_unit_tb.sv */
// Self-checking testbench for the multichannel convolution forward unit.
// Load requests and pixel frames go in under several geometries; a predictor
// computes each filter result and a monitor compares results in order.
// Depends on mcc2d_pkg and multichannel_conv2d_forward_unit.
`default_nettype none
module multichannel_conv2d_forward_unit_tb;
    import mcc2d_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multichannel_conv2d_forward_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state.
    logic signed [15:0] weight_mem [W_DEPTH];
    logic signed [15:0] bias_mem [B_DEPTH];
    logic signed [15:0] line_mem [L_DEPTH];
    logic [5:0]         reg_raw [6];
    int unsigned        pos_row, pos_col, pos_chan;

    t_in_item  pending_requests [$];
    t_out_item expected_results [$];
    int        error_count;
    int        requests_sent;
    int        results_seen;
    longint    cycle_count;
    bit        idle_enabled;
    int        send_gap;
    int        recv_gap;

    // Acceptance seen at the rising edge, used by the driver at the next falling edge.
    logic      o_ready_seen;

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = 1'b1;
            #10 i_clk = 1'b0;
        end
    end

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Works out the results one accepted request causes and queues them.
    task automatic predict_request(input t_in_item req);
        int unsigned ic, oc, kr, kc, ir, icw, orow, ocol, f, c, r, k;
        logic [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] acc_s;
        longint sum, val;
        bit last_win;
        t_out_item res;
        ic  = clamp_reg(reg_raw[REG_IN_CH], MAX_IN_CH);
        oc  = clamp_reg(reg_raw[REG_OUT_CH], MAX_OUT_CH);
        kr  = clamp_reg(reg_raw[REG_K_ROWS], MAX_K);
        kc  = clamp_reg(reg_raw[REG_K_COLS], MAX_K);
        ir  = clamp_reg(reg_raw[REG_I_ROWS], MAX_DIM);
        icw = clamp_reg(reg_raw[REG_I_COLS], MAX_DIM);
        if (req.cmd == CMD_WEIGHT) begin
            if (req.weight_addr < W_DEPTH) weight_mem[req.weight_addr] = req.sample;
            return;
        end
        if (req.cmd == CMD_BIAS) begin
            bias_mem[req.bias_addr] = req.sample;
            return;
        end
        if (req.cmd != CMD_PIXEL) return;
        if (pos_row >= ir || pos_col >= icw || pos_chan >= ic) begin
            pos_row = 0;
            pos_col = 0;
            pos_chan = 0;
        end
        line_mem[((pos_row % MAX_K) * MAX_DIM + pos_col) * MAX_IN_CH + pos_chan] = req.sample;
        if (pos_chan + 1 < ic) begin
            pos_chan++;
            return;
        end
        if (kr <= ir && kc <= icw && pos_row + 1 >= kr && pos_col + 1 >= kc) begin
            orow = pos_row + 1 - kr;
            ocol = pos_col + 1 - kc;
            last_win = (orow == ir - kr) && (ocol == icw - kc);
            for (f = 0; f < oc; f++) begin
                acc = '0;
                for (c = 0; c < ic; c++)
                    for (r = 0; r < kr; r++)
                        for (k = 0; k < kc; k++)
                            acc = acc + ACC_W'(longint'(line_mem[(((orow + r) % MAX_K)
                                * MAX_DIM + ocol + k) * MAX_IN_CH + c])
                                * longint'(weight_mem[((f * MAX_IN_CH + c) * MAX_K + r)
                                * MAX_K + k]));
                acc_s = acc;
                sum = longint'(acc_s >>> 12);
                val = sum + longint'(bias_mem[(f * MAX_DIM + orow) * MAX_DIM + ocol]);
                res.clipped = 1'b0;
                if (val > 32767) begin
                    val = 32767;
                    res.clipped = 1'b1;
                end
                if (val < -32768) begin
                    val = -32768;
                    res.clipped = 1'b1;
                end
                res.filter_index = f[3:0];
                res.out_row      = orow[4:0];
                res.out_col      = ocol[4:0];
                res.result_value = val[15:0];
                res.run_last     = (f + 1 == oc);
                res.frame_done   = (f + 1 == oc) && last_win;
                expected_results.push_back(res);
            end
        end
        pos_chan = 0;
        pos_col++;
        if (pos_col >= icw) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= ir) pos_row = 0;
        end
    endtask

    // Driver: the request at the head of the queue is held until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (pending_requests.size() > 0 && send_gap == 0) begin
                    i_item  <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                    if (idle_enabled && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
            if (recv_gap > 0) begin
                i_ready <= 1'b0;
                recv_gap--;
            end else begin
                i_ready <= 1'b1;
                if (idle_enabled && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            cycle_count++;
            if (i_valid && o_ready) begin
                predict_request(i_item);
                requests_sent++;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: filter %0d row %0d col %0d",
                           o_item.filter_index, o_item.out_row, o_item.out_col);
                    error_count++;
                end else begin
                    t_out_item exp_res;
                    exp_res = expected_results.pop_front();
                    if (o_item.filter_index !== exp_res.filter_index) begin
                        $error("filter_index: expected %0d, got %0d",
                               exp_res.filter_index, o_item.filter_index);
                        error_count++;
                    end
                    if (o_item.out_row !== exp_res.out_row) begin
                        $error("out_row: expected %0d, got %0d", exp_res.out_row, o_item.out_row);
                        error_count++;
                    end
                    if (o_item.out_col !== exp_res.out_col) begin
                        $error("out_col: expected %0d, got %0d", exp_res.out_col, o_item.out_col);
                        error_count++;
                    end
                    if (o_item.result_value !== exp_res.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               exp_res.result_value, o_item.result_value);
                        error_count++;
                    end
                    if (o_item.clipped !== exp_res.clipped) begin
                        $error("clipped: expected %0b, got %0b", exp_res.clipped, o_item.clipped);
                        error_count++;
                    end
                    if (o_item.run_last !== exp_res.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               exp_res.run_last, o_item.run_last);
                        error_count++;
                    end
                    if (o_item.frame_done !== exp_res.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               exp_res.frame_done, o_item.frame_done);
                        error_count++;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        // A trailing pixel may still be in the back part without any result due.
        repeat (1500) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [5:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        reg_raw[idx] = value & ((idx == REG_IN_CH) ? 6'hF : (idx == REG_OUT_CH) ? 6'h1F :
                       (idx == REG_K_ROWS || idx == REG_K_COLS) ? 6'h7 : 6'h3F);
        pos_row = 0;
        pos_col = 0;
        pos_chan = 0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_in_item make_load(input logic [1:0] cmd, input int unsigned addr,
                                           input logic [15:0] value);
        t_in_item it;
        it.cmd         = cmd;
        it.weight_addr = WA_W'($urandom());
        it.bias_addr   = BA_W'($urandom());
        it.sample      = value;
        if (cmd == CMD_WEIGHT) it.weight_addr = addr[11:0];
        if (cmd == CMD_BIAS) it.bias_addr = addr[13:0];
        return it;
    endfunction

    // Loads every weight and bias the geometry reads, then queues whole frames.
    task automatic queue_phase(input int unsigned ic, oc, kr, kc, ir, icw,
                               input int frames, input int wmode);
        int unsigned f, c, r, k, n;
        logic [15:0] v;
        if (kr <= ir && kc <= icw) begin
            for (f = 0; f < oc; f++)
                for (c = 0; c < ic; c++)
                    for (r = 0; r < kr; r++)
                        for (k = 0; k < kc; k++) begin
                            v = (wmode == 1) ? 16'h7FFF : (wmode == 2) ? 16'h8000 :
                                16'($urandom());
                            pending_requests.push_back(make_load(CMD_WEIGHT,
                                ((f * MAX_IN_CH + c) * MAX_K + r) * MAX_K + k, v));
                        end
            for (f = 0; f < oc; f++)
                for (r = 0; r + kr <= ir; r++)
                    for (k = 0; k + kc <= icw; k++)
                        pending_requests.push_back(make_load(CMD_BIAS,
                            (f * MAX_DIM + r) * MAX_DIM + k, 16'($urandom())));
        end
        for (n = 0; n < frames * ir * icw * ic; n++) begin
            v = (wmode == 1) ? 16'h7FFF : (wmode == 2) ? 16'h7FFF : 16'($urandom());
            pending_requests.push_back(make_load(CMD_PIXEL, 0, v));
            // Occasional noise: unknown commands and out-of-range weight writes.
            if ($urandom_range(0, 19) == 0)
                pending_requests.push_back(make_load(CMD_UNKNOWN, 0, 16'($urandom())));
            if ($urandom_range(0, 29) == 0)
                pending_requests.push_back(make_load(CMD_WEIGHT,
                    $urandom_range(W_DEPTH, 4095), 16'($urandom())));
        end
    endtask

    task automatic run_phase(input logic [5:0] ic, oc, kr, kc, ir, icw,
                             input int frames, input int wmode);
        write_register(REG_IN_CH, ic);
        write_register(REG_OUT_CH, oc);
        write_register(REG_K_ROWS, kr);
        write_register(REG_K_COLS, kc);
        write_register(REG_I_ROWS, ir);
        write_register(REG_I_COLS, icw);
        queue_phase(clamp_reg(reg_raw[REG_IN_CH], MAX_IN_CH),
                    clamp_reg(reg_raw[REG_OUT_CH], MAX_OUT_CH),
                    clamp_reg(reg_raw[REG_K_ROWS], MAX_K),
                    clamp_reg(reg_raw[REG_K_COLS], MAX_K),
                    clamp_reg(reg_raw[REG_I_ROWS], MAX_DIM),
                    clamp_reg(reg_raw[REG_I_COLS], MAX_DIM), frames, wmode);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        error_count = 0;
        requests_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        idle_enabled = 1'b1;
        send_gap = 0;
        recv_gap = 0;
        pos_row = 0;
        pos_col = 0;
        pos_chan = 0;
        reg_raw[0] = 1;
        reg_raw[1] = 1;
        reg_raw[2] = 3;
        reg_raw[3] = 3;
        reg_raw[4] = 32;
        reg_raw[5] = 32;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: saturation both ways, out-of-range registers, kernel larger than image.
        run_phase(6'd1, 6'd1, 6'd1, 6'd1, 6'd2, 6'd2, 1, 1);
        run_phase(6'd1, 6'd2, 6'd1, 6'd1, 6'd1, 6'd2, 1, 2);
        run_phase(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 1, 0);
        run_phase(6'd15, 6'd31, 6'd7, 6'd7, 6'd1, 6'd2, 1, 0);

        // Small geometries, a frame restart, the widest channel count and the tallest kernel.
        run_phase(6'd2, 6'd1, 6'd2, 6'd2, 6'd3, 6'd3, 1, 0);
        run_phase(6'd8, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 1, 0);
        run_phase(6'd1, 6'd2, 6'd2, 6'd1, 6'd3, 6'd2, 2, 0);
        run_phase(6'd1, 6'd1, 6'd5, 6'd1, 6'd6, 6'd2, 1, 0);
        idle_enabled = 1'b0;
        run_phase(6'd1, 6'd1, 6'd2, 6'd2, 6'd2, 6'd3, 2, 0);

        $display("Covered %0d accepted requests and %0d checked results over nine geometries,",
                 requests_sent, results_seen);
        $display("including saturation, clamped registers and kernels larger than the image.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
